@@ sv/lzss_pkg.sv @@
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int RING_SIZE   = 4096;
    localparam int RING_AW     = 12;
    localparam int FILL_W      = RING_AW + 1;
    localparam int LEN_W       = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_CNT_W   = 4;
    localparam int MIN_MATCH   = 3;
    localparam int LONG_CODE   = 15;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_WORD_HI,
        PH_EXT
    } phase_t;

    typedef struct packed {
        logic                 is_match;
        logic [7:0]           lit;
        logic [RING_AW-1:0]   pos;
        logic [LEN_W-1:0]     len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ sv/lzss_ring_decoder_core.sv @@
`timescale 1ns / 1ps

// LZSS decoder with a 4096-byte history ring. The parser takes one compressed
// byte per cycle and places literal and match commands in a four-entry queue;
// it stalls only when that queue is full. The copy engine writes one decoded
// byte per cycle into the ring through its single write port and read port
// unless output back-pressure stalls it; a literal yields one byte and a
// match yields its length (3 to 273 bytes). Decoded bytes leave in groups of
// up to OUT_LANES per item, the last group of each input byte marked with
// tlast. The ring reads as zero until written; a fill count tracks this, so
// there is no clearing pass and input is taken right after reset.
module lzss_ring_decoder_core #(
    parameter int OUT_LANES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // block_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] out_data, [67:64] out_count, [71:68] zero
    output logic        m_tlast    // out_last
);

    import lzss_pkg::*;

    q_stat_t                q_stat;
    cmd_t                   push_cmd;
    cmd_t                   head;
    logic                   push;
    logic                   pop;
    logic [OUT_DATA_W-1:0]  out_data;
    logic [OUT_CNT_W-1:0]   out_count;

    lzss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    lzss_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    lzss_back #(
        .OUT_LANES (OUT_LANES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .out_count (out_count),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_count, out_data};

`ifndef SYNTHESIS
    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_count != '0) && (out_count <= OUT_CNT_W'(OUT_LANES)))
        else $error("result byte count out of range");

    a_queue_stat : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({q_stat.full, q_stat.empty}))
        else $error("command queue both full and empty");

    a_pop_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("command taken from empty queue");

    a_push_room : assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("command pushed into full queue");
`endif

endmodule

@@ sv/lzss_ram.sv @@
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lzss_front.sv @@
`timescale 1ns / 1ps

module lzss_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  lzss_pkg::q_stat_t q_stat,
    output logic              push,
    output lzss_pkg::cmd_t    cmd
);

    import lzss_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [8:0]             flag_reg, flag_next;
    logic [7:0]             low_reg, low_next;
    logic [RING_AW-1:0]     pos_reg, pos_next;
    logic                   acc;
    logic [3:0]             nibble;
    logic [RING_AW-1:0]     word_pos;

    assign in_ready = !q_stat.full;
    assign acc      = in_valid && in_ready;
    assign nibble   = in_byte[7:4];
    assign word_pos = {in_byte[3:0], low_reg};

    always_comb begin
        phase_next = phase_reg;
        if (acc) begin
            case (phase_reg)
                PH_TOKEN: begin
                    if (flag_reg[0]) begin
                        phase_next = PH_WORD_HI;
                    end else begin
                        phase_next = (flag_reg[8:2] != '0) ? PH_TOKEN : PH_FLAG;
                    end
                end
                PH_WORD_HI: begin
                    if (nibble == 4'(LONG_CODE)) begin
                        phase_next = PH_EXT;
                    end else begin
                        phase_next = (flag_reg[8:1] != '0) ? PH_TOKEN : PH_FLAG;
                    end
                end
                PH_EXT: begin
                    phase_next = (flag_reg[8:1] != '0) ? PH_TOKEN : PH_FLAG;
                end
                default: begin
                    phase_next = PH_TOKEN;
                end
            endcase
            if (in_last) begin
                phase_next = PH_FLAG;
            end
        end
    end

    always_comb begin
        push         = 1'b0;
        cmd.is_match = 1'b0;
        cmd.lit      = in_byte;
        cmd.pos      = word_pos;
        cmd.len      = LEN_W'(1);
        flag_next    = flag_reg;
        low_next     = low_reg;
        pos_next     = pos_reg;
        if (acc) begin
            case (phase_reg)
                PH_TOKEN: begin
                    flag_next = {1'b0, flag_reg[8:1]};
                    if (flag_reg[0]) begin
                        low_next = in_byte;
                    end else begin
                        push = 1'b1;
                    end
                end
                PH_WORD_HI: begin
                    pos_next = word_pos;
                    if (nibble != 4'(LONG_CODE)) begin
                        push         = 1'b1;
                        cmd.is_match = 1'b1;
                        cmd.len      = {5'b0, nibble} + LEN_W'(MIN_MATCH);
                    end
                end
                PH_EXT: begin
                    push         = 1'b1;
                    cmd.is_match = 1'b1;
                    cmd.pos      = pos_reg;
                    cmd.len      = {1'b0, in_byte} + LEN_W'(LONG_CODE + MIN_MATCH);
                end
                default: begin
                    flag_next = {1'b1, in_byte};
                end
            endcase
            if (in_last) begin
                flag_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            low_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            low_reg   <= low_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

@@ sv/lzss_cmd_queue.sv @@
`timescale 1ns / 1ps

module lzss_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lzss_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output lzss_pkg::cmd_t    head,
    output lzss_pkg::q_stat_t stat
);

    import lzss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ sv/lzss_back.sv @@
`timescale 1ns / 1ps

module lzss_back #(
    parameter int OUT_LANES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lzss_pkg::cmd_t                  head,
    input  lzss_pkg::q_stat_t               q_stat,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lzss_pkg::OUT_DATA_W-1:0] out_data,
    output logic [lzss_pkg::OUT_CNT_W-1:0]  out_count,
    output logic                            out_last
);

    import lzss_pkg::*;

    // issue stage
    logic                   cmd_valid_reg, cmd_valid_next;
    logic                   cmd_match_reg, cmd_match_next;
    logic [7:0]             cmd_lit_reg, cmd_lit_next;
    logic [RING_AW-1:0]     rpos_reg, rpos_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;

    // data stage
    logic                   d_valid_reg, d_valid_next;
    logic                   d_lit_sel_reg, d_lit_sel_next;
    logic [7:0]             d_lit_reg, d_lit_next;
    logic                   d_end_reg, d_end_next;
    logic                   d_byp_reg, d_byp_next;
    logic [7:0]             d_byp_byte_reg, d_byp_byte_next;
    logic                   d_zero_reg, d_zero_next;

    logic [RING_AW-1:0]     wpos_reg, wpos_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;

    logic [OUT_DATA_W-1:0]  acc_data_reg, acc_data_next;
    logic [OUT_CNT_W-1:0]   acc_cnt_reg, acc_cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic [OUT_CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                   out_last_reg, out_last_next;

    logic [7:0]             ram_q;
    logic [7:0]             d_byte;
    logic [OUT_DATA_W-1:0]  d_shifted;
    logic                   flush;
    logic                   stall;
    logic                   d_adv;
    logic                   issue;
    logic                   cmd_last;

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .aclk  (aclk),
        .we    (d_adv),
        .waddr (wpos_reg),
        .wdata (d_byte),
        .re    (issue && cmd_match_reg),
        .raddr (rpos_reg),
        .rdata (ram_q)
    );

    always_comb begin
        if (d_lit_sel_reg) begin
            d_byte = d_lit_reg;
        end else if (d_byp_reg) begin
            d_byte = d_byp_byte_reg;
        end else if (d_zero_reg) begin
            d_byte = '0;
        end else begin
            d_byte = ram_q;
        end
        d_shifted = OUT_DATA_W'(d_byte) << {acc_cnt_reg[2:0], 3'b000};
        flush     = d_valid_reg && (d_end_reg || acc_cnt_reg == OUT_CNT_W'(OUT_LANES - 1));
        stall     = flush && out_valid_reg && !out_ready;
        d_adv     = d_valid_reg && !stall;
        issue     = cmd_valid_reg && !stall;
        cmd_last  = !cmd_match_reg || (rem_reg == LEN_W'(1));
        pop       = !q_stat.empty && (!cmd_valid_reg || (issue && cmd_last));
    end

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        cmd_match_next = cmd_match_reg;
        cmd_lit_next   = cmd_lit_reg;
        rpos_next      = rpos_reg;
        rem_next       = rem_reg;
        if (pop) begin
            cmd_valid_next = 1'b1;
            cmd_match_next = head.is_match;
            cmd_lit_next   = head.lit;
            rpos_next      = head.pos;
            rem_next       = head.len;
        end else if (issue && cmd_last) begin
            cmd_valid_next = 1'b0;
        end else if (issue) begin
            rpos_next = rpos_reg + RING_AW'(1);
            rem_next  = rem_reg - LEN_W'(1);
        end

        d_valid_next    = d_valid_reg;
        d_lit_sel_next  = d_lit_sel_reg;
        d_lit_next      = d_lit_reg;
        d_end_next      = d_end_reg;
        d_byp_next      = d_byp_reg;
        d_byp_byte_next = d_byp_byte_reg;
        d_zero_next     = d_zero_reg;
        if (issue) begin
            d_valid_next    = 1'b1;
            d_lit_sel_next  = !cmd_match_reg;
            d_lit_next      = cmd_lit_reg;
            d_end_next      = cmd_last;
            d_byp_next      = d_adv && (rpos_reg == wpos_reg);
            d_byp_byte_next = d_byte;
            d_zero_next     = !({1'b0, rpos_reg} < fill_reg);
        end else if (d_adv) begin
            d_valid_next = 1'b0;
        end

        wpos_next = wpos_reg;
        fill_next = fill_reg;
        if (d_adv) begin
            wpos_next = wpos_reg + RING_AW'(1);
            if (fill_reg != FILL_W'(RING_SIZE)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        acc_data_next  = acc_data_reg;
        acc_cnt_next   = acc_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (d_adv) begin
            if (flush) begin
                acc_data_next  = '0;
                acc_cnt_next   = '0;
                out_valid_next = 1'b1;
                out_data_next  = acc_data_reg | d_shifted;
                out_cnt_next   = acc_cnt_reg + OUT_CNT_W'(1);
                out_last_next  = d_end_reg;
            end else begin
                acc_data_next = acc_data_reg | d_shifted;
                acc_cnt_next  = acc_cnt_reg + OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_match_reg  <= cmd_match_next;
        cmd_lit_reg    <= cmd_lit_next;
        rpos_reg       <= rpos_next;
        rem_reg        <= rem_next;
        d_lit_sel_reg  <= d_lit_sel_next;
        d_lit_reg      <= d_lit_next;
        d_end_reg      <= d_end_next;
        d_byp_reg      <= d_byp_next;
        d_byp_byte_reg <= d_byp_byte_next;
        d_zero_reg     <= d_zero_next;
        out_data_reg   <= out_data_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            d_valid_reg   <= 1'b0;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            acc_data_reg  <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            d_valid_reg   <= d_valid_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            acc_data_reg  <= acc_data_next;
            acc_cnt_reg   <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_count = out_cnt_reg;
    assign out_last  = out_last_reg;

endmodule

@@ tb/tb_lzss_ring_decoder_core.sv @@
`timescale 1ns / 1ps

module tb_lzss_ring_decoder_core;

    import lzss_pkg::*;

    localparam int LANES      = 8;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int SETTLE     = 400;
    localparam int CUT_NONE   = 0;
    localparam int CUT_LOW    = 1;
    localparam int CUT_HIGH   = 2;
    localparam int CUT_END    = 3;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
    } lane_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    // decoder state mirrored on the testbench side
    logic [7:0]  hist_ring [RING_SIZE];
    logic [11:0] wr_pos;
    logic [8:0]  flag_bits;
    phase_t      parse_ph;
    logic [7:0]  word_lo;
    logic [11:0] copy_pos;
    logic [3:0]  len_code;
    logic [63:0] lane_data;
    int          lane_fill;
    bit          ring_wrapped;

    lane_t       lanes_due[$];

    int          src_idle_pct;
    int          stall_pct;
    int          hold_left;
    int          items_sent;
    int          bytes_decoded;
    int          lanes_checked;
    int          input_stalls;
    int          errors;
    int          cycles;

    lzss_ring_decoder_core #(
        .OUT_LANES(LANES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic flush_lane();
        if (lane_fill == 0)
            return;
        lanes_due.push_back('{lane_data, 4'(lane_fill), 1'b0});
        lane_data = '0;
        lane_fill = 0;
    endtask

    task automatic put_byte(input logic [7:0] b);
        hist_ring[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        if (wr_pos == 12'd0)
            ring_wrapped = 1'b1;
        lane_data[8*lane_fill +: 8] = b;
        lane_fill++;
        bytes_decoded++;
        if (lane_fill == LANES)
            flush_lane();
    endtask

    task automatic copy_run(input int len);
        for (int i = 0; i < len; i++) begin
            put_byte(hist_ring[copy_pos]);
            copy_pos = copy_pos + 12'd1;
        end
    endtask

    task automatic end_token();
        parse_ph = (flag_bits > 9'd1) ? PH_TOKEN : PH_FLAG;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic blast);
        int    due_start;
        lane_t tail;
        logic  tok;
        due_start = lanes_due.size();
        case (parse_ph)
            PH_TOKEN: begin
                tok = flag_bits[0];
                flag_bits = flag_bits >> 1;
                if (tok) begin
                    word_lo = b;
                    parse_ph = PH_WORD_HI;
                end else begin
                    put_byte(b);
                    end_token();
                end
            end
            PH_WORD_HI: begin
                copy_pos = {b[3:0], word_lo};
                len_code = b[7:4];
                if (len_code == LONG_CODE) begin
                    parse_ph = PH_EXT;
                end else begin
                    copy_run(int'(len_code) + MIN_MATCH);
                    end_token();
                end
            end
            PH_EXT: begin
                copy_run(LONG_CODE + int'(b) + MIN_MATCH);
                end_token();
            end
            default: begin
                flag_bits = {1'b1, b};
                parse_ph = PH_TOKEN;
            end
        endcase
        flush_lane();
        if (lanes_due.size() > due_start) begin
            tail = lanes_due.pop_back();
            tail.last = 1'b1;
            lanes_due.push_back(tail);
        end
        if (blast) begin
            parse_ph = PH_FLAG;
            flag_bits = '0;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic blast);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom);
            s_tlast = 1'($urandom);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = blast;
        do
            @(posedge aclk);
        while (!s_tready);
        decode_byte(b, blast);
        items_sent++;
    endtask

    task automatic send_match(input logic [11:0] pos, input logic [3:0] code,
                              input logic [7:0] ext, input int cut);
        send_item(pos[7:0], cut == CUT_LOW);
        if (cut == CUT_LOW)
            return;
        send_item({code, pos[11:8]},
                  cut == CUT_HIGH || (cut == CUT_END && code != LONG_CODE));
        if (code != LONG_CODE || cut == CUT_HIGH)
            return;
        send_item(ext, cut == CUT_END);
    endtask

    function automatic logic [11:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 12'($urandom);
        if (r < 3)
            return wr_pos - 12'($urandom_range(1, 4));
        return wr_pos - 12'($urandom_range(1, 300));
    endfunction

    function automatic logic [3:0] pick_code();
        return ($urandom_range(0, 9) == 0) ? 4'(LONG_CODE) : 4'($urandom_range(0, 14));
    endfunction

    function automatic logic [7:0] pick_ext();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    endfunction

    task automatic send_random_group();
        logic [7:0] f;
        int         stop;
        int         r;
        int         cut;
        f = 8'($urandom);
        r = $urandom_range(0, 9);
        stop = (r == 0) ? -1 : (r <= 3) ? $urandom_range(0, 7) : 8;
        send_item(f, stop < 0);
        if (stop < 0)
            return;
        for (int k = 0; k < 8; k++) begin
            if (f[k]) begin
                cut = (k == stop) ? $urandom_range(CUT_LOW, CUT_END) : CUT_NONE;
                send_match(pick_pos(), pick_code(), pick_ext(), cut);
            end else begin
                send_item(8'($urandom), k == stop);
            end
            if (k == stop)
                return;
        end
    endtask

    task automatic send_noise();
        int k;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
            send_item(8'($urandom), i == k - 1);
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (lanes_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_literals();
        src_idle_pct = 0;
        stall_pct = 0;
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hFE, 1'b0);
    endtask

    task automatic test_matches();
        send_item(8'h07, 1'b0);
        send_match(wr_pos - 12'd8, 4'd0, 8'h00, CUT_NONE);
        send_match(wr_pos - 12'd1, 4'(LONG_CODE), 8'hFF, CUT_NONE);
        send_match(12'hFFE, 4'd14, 8'h00, CUT_NONE);
        // literal ending the block drops the unused flag bits
        send_item(8'hC3, 1'b1);
    endtask

    task automatic test_block_end();
        send_item(8'h01, 1'b0);
        send_match(wr_pos - 12'd5, 4'd2, 8'h00, CUT_LOW);
        send_item(8'h01, 1'b0);
        send_match(wr_pos - 12'd5, 4'(LONG_CODE), 8'h00, CUT_HIGH);
        send_item(8'hA5, 1'b1);
        send_item(8'h02, 1'b0);
        send_item(8'h3C, 1'b0);
        send_match(wr_pos - 12'd2, 4'd5, 8'h00, CUT_END);
    endtask

    task automatic test_ring_wrap();
        while (!ring_wrapped) begin
            send_item(8'hFF, 1'b0);
            for (int k = 0; k < 8; k++)
                send_match(pick_pos(), 4'(LONG_CODE), 8'hFF, CUT_NONE);
        end
    endtask

    task automatic test_random(input int src, input int snk, input int n);
        int start;
        src_idle_pct = src;
        stall_pct = snk;
        start = items_sent;
        while (items_sent - start < n) begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_random_group();
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        stall_pct = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        hold_left = 400;
        send_item(8'h00, 1'b0);
        for (int k = 0; k < 8; k++)
            send_item(8'($urandom), 1'b0);
        repeat (3) send_random_group();
    endtask

    task automatic test_drain_pause();
        src_idle_pct = 22;
        stall_pct = 22;
        repeat (2) begin
            send_random_group();
            pause_until_drained();
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        lane_t want;
        if (aresetn && s_tvalid && !s_tready)
            input_stalls++;
        if (aresetn && m_tvalid && m_tready) begin
            if (lanes_due.size() == 0) begin
                $display("%0t: unexpected output item, got data %h count %0d last %b",
                         $time, m_tdata[63:0], m_tdata[67:64], m_tlast);
                errors++;
            end else begin
                want = lanes_due.pop_front();
                lanes_checked++;
                if (m_tdata[63:0] !== want.data) begin
                    $display("%0t: out_data expected %h, got %h",
                             $time, want.data, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[71:64] !== {4'b0, want.count}) begin
                    $display("%0t: out_count expected %0d, got %h",
                             $time, want.count, m_tdata[71:64]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last expected %b, got %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        src_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        items_sent = 0;
        bytes_decoded = 0;
        lanes_checked = 0;
        input_stalls = 0;
        errors = 0;
        cycles = 0;
        for (int i = 0; i < RING_SIZE; i++)
            hist_ring[i] = '0;
        wr_pos = '0;
        flag_bits = '0;
        parse_ph = PH_FLAG;
        word_lo = '0;
        copy_pos = '0;
        len_code = '0;
        lane_data = '0;
        lane_fill = 0;
        ring_wrapped = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_literals();
        test_matches();
        test_block_end();
        test_ring_wrap();
        test_random(0, 0, 45);
        test_random(74, 0, 45);
        test_random(0, 74, 45);
        test_random(22, 22, 45);
        test_backpressure();
        test_drain_pause();

        src_idle_pct = 0;
        stall_pct = 0;
        pause_until_drained();
        repeat (SETTLE) @(posedge aclk);

        if (lanes_due.size() != 0) begin
            $display("%0t: %0d output items never arrived", $time, lanes_due.size());
            errors++;
        end
        $display("Covered %0d input bytes decoding to %0d bytes in %0d output items",
                 items_sent, bytes_decoded, lanes_checked);
        $display("Ring wrapped: %0s; %0d cycles with input held off by the decoder",
                 ring_wrapped ? "yes" : "no", input_stalls);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lzss_pkg.sv
sv/lzss_ram.sv
sv/lzss_front.sv
sv/lzss_cmd_queue.sv
sv/lzss_back.sv
sv/lzss_ring_decoder_core.sv
tb/tb_lzss_ring_decoder_core.sv
